// ===== design/twa_pkg.sv =====
// Package for the time window average block: sizes, register codes, beat types.
// No dependencies; every design file imports it.
`default_nettype none
package twa_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 20;
  localparam int TIME_BITS  = 32;
  localparam int WIN_BITS   = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int SUM_BITS   = VALUE_BITS + CNT_BITS;
  localparam int STEP_BITS  = $clog2(SUM_BITS);
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WIN_BITS-1:0] SHORT_RESET = WIN_BITS'(60 * 60);
  localparam logic [WIN_BITS-1:0] LONG_RESET  = WIN_BITS'(60 * 60 * 8);

  localparam logic [CFG_IDX_W-1:0] REG_SHORT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [TIME_BITS-1:0]         sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] short_average;
    logic signed [VALUE_BITS-1:0] long_average;
    logic [COUNT_W-1:0]           short_count;
    logic [COUNT_W-1:0]           long_count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         stime;
    logic signed [VALUE_BITS-1:0] svalue;
  } mem_word_t;

  typedef struct packed {
    logic                 valid;
    logic [IDX_BITS-1:0]  newest;
    logic [CNT_BITS-1:0]  fill;
    logic [TIME_BITS-1:0] now;
  } job_t;

endpackage
`default_nettype wire

// ===== design/twa_front.sv =====
// Front part: accepts samples, writes the ring store, hands one job to the back part.
// Depends on twa_pkg. Holds the sample memory and its registered read port.
`default_nettype none
module twa_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire twa_pkg::in_item_t in_item,
  output twa_pkg::job_t         job,
  input  wire logic             job_take,
  input  wire logic             walk_busy,
  input  wire logic [twa_pkg::IDX_BITS-1:0] rd_addr,
  output twa_pkg::mem_word_t    rd_data
);
  import twa_pkg::*;

  mem_word_t           mem [DEPTH];
  logic [IDX_BITS-1:0] wp;
  logic [CNT_BITS-1:0] fill;
  logic [CNT_BITS-1:0] fill_next;
  logic                accept;

  assign full      = job.valid || walk_busy;
  assign accept    = push && !full;
  assign fill_next = (fill == CNT_BITS'(DEPTH)) ? fill : fill + CNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp] <= '{stime: in_item.sample_time, svalue: in_item.sample_value};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      fill      <= '0;
      job.valid <= 1'b0;
    end else begin
      if (job_take) job.valid <= 1'b0;
      if (accept) begin
        job.valid  <= 1'b1;
        job.newest <= wp;
        job.fill   <= fill_next;
        job.now    <= in_item.sample_time;
        fill       <= fill_next;
        wp         <= (wp == IDX_BITS'(DEPTH - 1)) ? '0 : wp + IDX_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/twa_back.sv =====
// Back part: walks both windows over the ring store, divides, holds the result beat.
// Depends on twa_pkg; reads the store through the front part's read port.
`default_nettype none
module twa_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire twa_pkg::job_t               job,
  output logic                             job_take,
  output logic                             walk_busy,
  output logic [twa_pkg::IDX_BITS-1:0]     rd_addr,
  input  wire twa_pkg::mem_word_t          rd_data,
  input  wire logic [twa_pkg::WIN_BITS-1:0] short_win,
  input  wire logic [twa_pkg::WIN_BITS-1:0] long_win,
  output logic                             empty,
  input  wire logic                        pop,
  output twa_pkg::out_item_t               out_item
);
  import twa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]           state;
  logic [IDX_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]  fill;
  logic [CNT_BITS-1:0]  walked;
  logic [TIME_BITS-1:0] now;
  logic                 s_done, l_done;
  logic [SUM_BITS-1:0]  s_sum, l_sum;
  logic [CNT_BITS-1:0]  s_cnt, l_cnt;
  logic                 s_neg, l_neg;
  logic [SUM_BITS-1:0]  s_q, l_q;
  logic [CNT_BITS-1:0]  s_rem, l_rem;
  logic [STEP_BITS-1:0] step;
  logic                 out_valid;

  logic [SUM_BITS-1:0]  val_ext;
  logic                 older;
  logic [TIME_BITS-1:0] age;
  logic                 s_hit, l_hit;
  logic [SUM_BITS-1:0]  s_sum_next, l_sum_next;
  logic [CNT_BITS-1:0]  s_cnt_next, l_cnt_next;
  logic                 s_done_next, l_done_next;
  logic [CNT_BITS-1:0]  walked_next;
  logic [CNT_BITS:0]    s_r2, l_r2;
  logic                 s_ge, l_ge;

  assign rd_addr   = idx;
  assign walk_busy = (state == S_ADDR) || (state == S_ACC);
  assign job_take  = (state == S_IDLE) && job.valid;
  assign empty     = !out_valid;

  always_comb begin
    val_ext     = {{(SUM_BITS-VALUE_BITS){rd_data.svalue[VALUE_BITS-1]}}, rd_data.svalue};
    older       = now >= rd_data.stime;
    age         = now - rd_data.stime;
    s_hit       = older && (age >= short_win);
    l_hit       = older && (age >= long_win);
    s_sum_next  = s_done ? s_sum : s_sum + val_ext;
    l_sum_next  = l_done ? l_sum : l_sum + val_ext;
    s_cnt_next  = s_done ? s_cnt : s_cnt + CNT_BITS'(1);
    l_cnt_next  = l_done ? l_cnt : l_cnt + CNT_BITS'(1);
    s_done_next = s_done || s_hit;
    l_done_next = l_done || l_hit;
    walked_next = walked + CNT_BITS'(1);
    s_r2        = {s_rem, s_q[SUM_BITS-1]};
    l_r2        = {l_rem, l_q[SUM_BITS-1]};
    s_ge        = s_r2 >= {1'b0, s_cnt};
    l_ge        = l_r2 >= {1'b0, l_cnt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && (state != S_OUT)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job.valid) begin
            idx    <= job.newest;
            fill   <= job.fill;
            now    <= job.now;
            walked <= '0;
            s_sum  <= '0;
            l_sum  <= '0;
            s_cnt  <= '0;
            l_cnt  <= '0;
            s_done <= 1'b0;
            l_done <= 1'b0;
            state  <= S_ADDR;
          end
        end
        S_ADDR: state <= S_ACC;
        S_ACC: begin
          s_sum  <= s_sum_next;
          l_sum  <= l_sum_next;
          s_cnt  <= s_cnt_next;
          l_cnt  <= l_cnt_next;
          s_done <= s_done_next;
          l_done <= l_done_next;
          walked <= walked_next;
          idx    <= (idx == '0) ? IDX_BITS'(DEPTH - 1) : idx - IDX_BITS'(1);
          if ((s_done_next && l_done_next) || (walked_next == fill)) begin
            s_neg <= s_sum_next[SUM_BITS-1];
            l_neg <= l_sum_next[SUM_BITS-1];
            s_q   <= s_sum_next[SUM_BITS-1] ? -s_sum_next : s_sum_next;
            l_q   <= l_sum_next[SUM_BITS-1] ? -l_sum_next : l_sum_next;
            s_rem <= '0;
            l_rem <= '0;
            step  <= '0;
            state <= S_DIV;
          end else begin
            state <= S_ADDR;
          end
        end
        S_DIV: begin
          s_rem <= s_ge ? CNT_BITS'(s_r2 - {1'b0, s_cnt}) : s_r2[CNT_BITS-1:0];
          l_rem <= l_ge ? CNT_BITS'(l_r2 - {1'b0, l_cnt}) : l_r2[CNT_BITS-1:0];
          s_q   <= {s_q[SUM_BITS-2:0], s_ge};
          l_q   <= {l_q[SUM_BITS-2:0], l_ge};
          step  <= step + STEP_BITS'(1);
          if (step == STEP_BITS'(SUM_BITS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || pop) begin
            out_item.short_average <= s_neg ? VALUE_BITS'(-s_q) : VALUE_BITS'(s_q);
            out_item.long_average  <= l_neg ? VALUE_BITS'(-l_q) : VALUE_BITS'(l_q);
            out_item.short_count   <= COUNT_W'(s_cnt);
            out_item.long_count    <= COUNT_W'(l_cnt);
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_acc_after_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> ($past(state) == S_ADDR))
    else $error("walk accumulate without a read");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (s_cnt <= fill && l_cnt <= fill && s_cnt != '0 && l_cnt != '0))
    else $error("window count out of range");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    job_take |-> !walk_busy)
    else $error("job taken while walking");

endmodule
`default_nettype wire

// ===== design/time_window_average_top.sv =====
// Top level of the time window average block: window registers and the two parts.
// Depends on twa_pkg, twa_front and twa_back.
//
// Input channel: in_item is taken when push is high and full is low, into a ring
// of DEPTH entries. The user alone ensures samples carry non-decreasing times.
// Result channel: the oldest result is on out_item while empty is low and
// leaves when pop is high. One result per sample, in order.
// Config channel: cfg_ready is always high; index 0 writes the short window,
// index 1 the long window, other indexes are ignored. Write only when idle.
// The accepted sample becomes a registered job; the back part takes it and walks
// the stored entries from the newest back, each through an address state and an
// accumulate state around the registered store read, for both windows at once,
// then runs restoring division for both windows in parallel and loads the beat.
// full stays high while a job waits or the walk runs; the next sample is
// taken during division. A stalled result holds the back part after its
// division, and full then rises once one further sample is queued.
// Reset clears pointers, fill and the handshake state and loads the window
// lengths of one hour and eight hours; no store clearing is needed.
`default_nettype none
module time_window_average_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire twa_pkg::in_item_t             in_item,
  output logic                               empty,
  input  wire logic                          pop,
  output twa_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [twa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [twa_pkg::WIN_BITS-1:0]  cfg_data
);
  import twa_pkg::*;

  logic [WIN_BITS-1:0] short_win;
  logic [WIN_BITS-1:0] long_win;
  job_t                job;
  logic                job_take;
  logic                walk_busy;
  logic [IDX_BITS-1:0] rd_addr;
  mem_word_t           rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_win <= SHORT_RESET;
      long_win  <= LONG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SHORT) short_win <= cfg_data;
      if (cfg_index == REG_LONG)  long_win  <= cfg_data;
    end
  end

  twa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .job       (job),
    .job_take  (job_take),
    .walk_busy (walk_busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  twa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_take  (job_take),
    .walk_busy (walk_busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .short_win (short_win),
    .long_win  (long_win),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for time_window_average_top: queued samples and window
// writes feed a clocked driver, a clocked monitor checks results against a predictor.
// Depends on twa_pkg and the time_window_average_top RTL.
`timescale 1ns / 1ps
module tb_top;
  import twa_pkg::*;

  typedef enum logic [1:0] {ACT_SAMPLE, ACT_WRITE, ACT_DRAIN} act_e;
  typedef struct {
    act_e                  kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [WIN_BITS-1:0]   data;
    in_item_t              item;
  } act_t;

  localparam int WATCHDOG = 40000;

  logic clk = 1'b0, rst = 1'b1;
  logic push = 1'b0, pop = 1'b0, cfg_valid = 1'b0;
  logic full, empty, cfg_ready;
  in_item_t in_item = '0;
  out_item_t out_item;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIN_BITS-1:0] cfg_data = '0;

  act_t      stim_q[$];
  out_item_t avg_expect_q[$];
  int        errors = 0;
  int        samples_taken = 0;
  bit        stim_done = 1'b0;

  // predictor state
  logic [TIME_BITS-1:0]         ring_time[DEPTH];
  logic signed [VALUE_BITS-1:0] ring_value[DEPTH];
  int                           ring_wp = 0;
  int                           ring_fill = 0;
  logic [WIN_BITS-1:0]          short_win = SHORT_RESET;
  logic [WIN_BITS-1:0]          long_win = LONG_RESET;

  time_window_average_top u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void walk_window(int newest, logic [WIN_BITS-1:0] win,
                                      output longint sum, output int cnt);
    longint now_t;
    int     idx;
    now_t = longint'(ring_time[newest]);
    sum = 0;
    cnt = 0;
    for (int k = 0; k < ring_fill; k++) begin
      idx = (newest + DEPTH - k) % DEPTH;
      sum += longint'(ring_value[idx]);
      cnt++;
      if (now_t - longint'(ring_time[idx]) >= longint'(win)) break;
    end
  endfunction

  function automatic out_item_t predict_averages(in_item_t it);
    out_item_t r;
    longint    s_sum, l_sum, s_avg, l_avg;
    int        s_cnt, l_cnt, newest;
    newest = ring_wp;
    ring_time[newest] = it.sample_time;
    ring_value[newest] = it.sample_value;
    ring_wp = (newest + 1) % DEPTH;
    if (ring_fill < DEPTH) ring_fill++;
    walk_window(newest, short_win, s_sum, s_cnt);
    walk_window(newest, long_win, l_sum, l_cnt);
    s_avg = s_sum / s_cnt;
    l_avg = l_sum / l_cnt;
    r.short_average = s_avg[VALUE_BITS-1:0];
    r.long_average  = l_avg[VALUE_BITS-1:0];
    r.short_count   = COUNT_W'(s_cnt);
    r.long_count    = COUNT_W'(l_cnt);
    return r;
  endfunction

  function automatic bit calm();
    return samples_taken >= 300 && samples_taken < 500;
  endfunction

  // driver
  int settle_cnt = 0;
  always @(posedge clk) begin
    logic next_push, next_cfg;
    act_t a;
    next_push = push;
    next_cfg = cfg_valid;
    if (rst) begin
      next_push = 1'b0;
      next_cfg = 1'b0;
    end else begin
      if (push && !full) begin
        avg_expect_q.push_back(predict_averages(in_item));
        samples_taken++;
        next_push = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SHORT) short_win = cfg_data;
        else if (cfg_index == REG_LONG) long_win = cfg_data;
        next_cfg = 1'b0;
      end
      if (!next_push && !next_cfg) begin
        if (settle_cnt > 0) begin
          settle_cnt--;
        end else if (stim_q.size() == 0) begin
          stim_done = 1'b1;
        end else begin
          a = stim_q[0];
          case (a.kind)
            ACT_DRAIN: begin
              if (avg_expect_q.size() == 0) begin
                settle_cnt = 60;
                void'(stim_q.pop_front());
              end
            end
            ACT_WRITE: begin
              next_cfg = 1'b1;
              cfg_index <= a.idx;
              cfg_data <= a.data;
              void'(stim_q.pop_front());
            end
            default: begin
              if (calm() || $urandom_range(0, 99) >= 32) begin
                next_push = 1'b1;
                in_item <= a.item;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
      end
    end
    push <= next_push;
    cfg_valid <= next_cfg;
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (avg_expect_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_r = avg_expect_q.pop_front();
          if (out_item.short_average !== exp_r.short_average) begin
            $error("short_average exp %0d got %0d", exp_r.short_average,
                   out_item.short_average);
            errors++;
          end
          if (out_item.long_average !== exp_r.long_average) begin
            $error("long_average exp %0d got %0d", exp_r.long_average,
                   out_item.long_average);
            errors++;
          end
          if (out_item.short_count !== exp_r.short_count) begin
            $error("short_count exp %0d got %0d", exp_r.short_count, out_item.short_count);
            errors++;
          end
          if (out_item.long_count !== exp_r.long_count) begin
            $error("long_count exp %0d got %0d", exp_r.long_count, out_item.long_count);
            errors++;
          end
        end
      end
      pop <= calm() || $urandom_range(0, 99) >= 32;
    end
  end

  // watchdog on cycles without any accepted beat
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  logic [TIME_BITS-1:0] t_now = '0;

  task automatic add_sample(logic [TIME_BITS-1:0] t, logic [VALUE_BITS-1:0] v);
    act_t a;
    a.kind = ACT_SAMPLE;
    a.idx = '0;
    a.data = '0;
    a.item.sample_time = t;
    a.item.sample_value = v;
    stim_q.push_back(a);
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [WIN_BITS-1:0] d);
    act_t a;
    a.kind = ACT_WRITE;
    a.idx = idx;
    a.data = d;
    a.item = '0;
    stim_q.push_back(a);
  endtask

  task automatic add_drain();
    act_t a;
    a.kind = ACT_DRAIN;
    a.idx = '0;
    a.data = '0;
    a.item = '0;
    stim_q.push_back(a);
  endtask

  task automatic set_windows(logic [WIN_BITS-1:0] sw, logic [WIN_BITS-1:0] lw);
    add_drain();
    add_write(REG_SHORT, sw);
    add_write(REG_LONG, lw);
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
      1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic advance(longint inc);
    longint nt;
    nt = longint'(t_now) + inc;
    t_now = (nt > 64'hFFFF_FFFF) ? '1 : TIME_BITS'(nt);
  endtask

  task automatic rand_phase(int n, int max_inc);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) advance($urandom_range(0, 1 << 24));
      else if ($urandom_range(0, 4) == 0) advance(0);
      else advance($urandom_range(0, max_inc));
      add_sample(t_now, rand_value());
    end
  endtask

  initial begin
    int sw;
    // defaults: extremes of value, equal times, time going backwards
    add_sample(0, {1'b1, {(VALUE_BITS-1){1'b0}}});
    add_sample(0, {1'b0, {(VALUE_BITS-1){1'b1}}});
    add_sample(0, 0);
    add_sample(1, '1);
    add_sample(3600, 16);
    add_sample(3599, 5);
    add_sample(3601, -20'sd100);
    add_sample(28800, 7);
    add_sample(28801, {1'b1, {(VALUE_BITS-1){1'b0}}});
    add_sample(40000, 3);
    // zero-length short window, ignored register indexes
    set_windows(0, 1);
    add_write(2'd2, 32'h5555_5555);
    add_write(2'd3, 32'hAAAA_AAAA);
    add_sample(40000, 9);
    add_sample(40001, -20'sd9);
    add_sample(40001, 1);
    set_windows(1, 1);
    add_sample(40002, 100);
    add_sample(40002, -20'sd3);
    // widest windows, store still small
    set_windows('1, '1);
    t_now = 40002;
    rand_phase(10, 50);
    // random phases
    for (int p = 0; p < 6; p++) begin
      sw = $urandom_range(1, 5000);
      set_windows(sw, sw * $urandom_range(1, 16));
      if (p == 3) t_now = 32'h8000_0000 + $urandom_range(0, 1 << 20);
      rand_phase(200, sw);
    end
    // top of the time range
    set_windows(100, 2000);
    t_now = 32'hFFFF_F000;
    rand_phase(30, 300);
    add_sample('1, 1);
    add_sample('1, -20'sd1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (!stim_done || avg_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
